FILE: hw/rtl/lfu_pkg.sv
// Shared types and constants for the LFU cache with LRU tie break.
// No dependencies; imported by lfu_ctrl, lfu_datapath and the top level.
package lfu_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int KEY_W        = 32;
   localparam int DATA_W       = 32;
   localparam int COUNT_W      = 32;
   localparam int STAMP_W      = 48;
   localparam int CAP_REG_W    = 5;

   localparam logic [CAP_REG_W-1:0] CAP_RESET = 5'd16;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   localparam logic [DATA_W-1:0] MISS_VALUE = '1;   // -1

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic load_req;   // latch request, restart scan
      logic scan_step;  // issue next entry read
      logic commit;     // apply update to entry store
      logic rsp_load;   // move result into output register
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_last;  // last entry being evaluated this cycle
      logic rsp_free;   // output register empty or being taken
   } ctrl_status_type;

   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [COUNT_W-1:0] count;
      logic [DATA_W-1:0]  data;
      logic [KEY_W-1:0]   key;
   } entry_type;

endpackage

FILE: hw/rtl/lfu_cache_lru_tiebreak.sv
// Top level of the LFU key-value cache with least-recently-used tie break.
// Depends on lfu_pkg, lfu_ctrl and lfu_datapath.
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/req_tready  tuser: cmd; tdata: key, value
//   rsp_     out  rsp_tvalid/rsp_tready  tuser: hit; tdata: read_value
//   csr_     in   csr_valid/csr_ready    csr_wdata: capacity_in_use
//
// Each request is accepted, then sweeps the single read port of the entry
// store (one entry a cycle, read data registered), then is written back.
// Reset clears valid bits, access clock and capacity (to 16) at once; the
// entry store itself needs no clearing pass.
// The result sits in an output register; a stalled rsp_ holds the next
// request only at write-back time, never at acceptance.
module lfu_cache_lru_tiebreak
   import lfu_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // request words
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [0:0]           req_tuser,   // [0] cmd (0 get, 1 put)
   input  logic [63:0]          req_tdata,   // [31:0] key, [63:32] value
   // result words
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [0:0]           rsp_tuser,   // [0] hit
   output logic [31:0]          rsp_tdata,   // [31:0] read_value
   // capacity register write
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CAP_REG_W-1:0] csr_wdata
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // register writes must be made only while idle (unchecked); always ready
   assign csr_ready = 1'b1;

   lfu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   lfu_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid && csr_ready),
      .csr_wdata  (csr_wdata)
   );

endmodule

FILE: hw/rtl/lfu_ctrl.sv
// Sequencer for the LFU cache: accept, scan, commit, hand result over.
// Depends on lfu_pkg.
module lfu_ctrl
   import lfu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output ctrl_cmd_type    cmd,
   input  ctrl_status_type status
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commit happens exactly once, right after the scan ends
   a_commit_after_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && status.scan_last |=> cmd.commit)
      else $error("commit did not follow end of scan");

   a_one_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> !cmd.commit)
      else $error("commit repeated");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> !req_tready)
      else $error("request accepted while busy");

endmodule

FILE: hw/rtl/lfu_datapath.sv
// Entry store, scan trackers, replacement decision and output register.
// Depends on lfu_pkg; driven by lfu_ctrl through ctrl_cmd_type.
module lfu_datapath
   import lfu_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   output ctrl_status_type      status,
   input  logic [0:0]           req_tuser,
   input  logic [63:0]          req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [0:0]           rsp_tuser,
   output logic [31:0]          rsp_tdata,
   input  logic                 csr_valid,
   input  logic [CAP_REG_W-1:0] csr_wdata
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > CAP_REG_W) ? CNT_W : CAP_REG_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   // configuration
   logic [CAP_REG_W-1:0] cap_ff;

   // request word
   logic               req_cmd_ff;
   logic [KEY_W-1:0]   req_key_ff;
   logic [DATA_W-1:0]  req_val_ff;

   // entry store and state
   entry_type             entry_mem [CAPACITY];
   entry_type             rd_data_ff;
   logic [CAPACITY-1:0]   valid_ff;
   logic [STAMP_W-1:0]    clock_ff;

   // scan pipeline
   logic [IDX_W-1:0] addr_ff;
   logic             addr_done_ff;
   logic             eval_vld_ff;
   logic [IDX_W-1:0] eval_idx_ff;

   // trackers
   logic               match_found_ff;
   logic [IDX_W-1:0]   match_idx_ff;
   logic [DATA_W-1:0]  match_data_ff;
   logic [COUNT_W-1:0] match_count_ff;
   logic               free_found_ff;
   logic [IDX_W-1:0]   free_idx_ff;
   logic               victim_found_ff;
   logic [IDX_W-1:0]   victim_idx_ff;
   logic [COUNT_W-1:0] victim_count_ff;
   logic [STAMP_W-1:0] victim_stamp_ff;
   logic [CNT_W-1:0]   used_ff;

   // output register
   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic [DATA_W-1:0]  rsp_data_ff;

   // decision
   logic               ev_valid;
   logic               ev_better;
   logic [CMP_W-1:0]   cap_ext;
   logic [CMP_W-1:0]   cap_eff;
   logic               full;
   logic               wr_en;
   logic               insert;
   logic [IDX_W-1:0]   wr_idx;
   entry_type          wr_entry;
   logic [COUNT_W-1:0] count_inc;
   logic [DATA_W-1:0]  res_data;

   assign ev_valid  = valid_ff[eval_idx_ff];
   assign ev_better = !victim_found_ff
                   || (rd_data_ff.count < victim_count_ff)
                   || (rd_data_ff.count == victim_count_ff
                       && rd_data_ff.stamp < victim_stamp_ff);

   assign cap_ext   = CMP_W'(cap_ff);
   assign cap_eff   = (cap_ext > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : cap_ext;
   assign full      = CMP_W'(used_ff) >= cap_eff;
   assign count_inc = (match_count_ff == '1) ? match_count_ff : match_count_ff + 1'b1;

   always_comb begin
      wr_en          = 1'b0;
      insert         = 1'b0;
      wr_idx         = match_idx_ff;
      wr_entry.key   = req_key_ff;
      wr_entry.data  = match_data_ff;
      wr_entry.count = count_inc;
      wr_entry.stamp = clock_ff;
      res_data       = '0;
      if (req_cmd_ff == CMD_GET) begin
         if (match_found_ff) begin
            wr_en    = 1'b1;
            res_data = match_data_ff;
         end else begin
            res_data = MISS_VALUE;
         end
      end else if (cap_eff != '0) begin
         wr_en         = 1'b1;
         wr_entry.data = req_val_ff;
         if (!match_found_ff) begin
            insert         = 1'b1;
            wr_idx         = full ? victim_idx_ff : free_idx_ff;
            wr_entry.count = COUNT_W'(1);
         end
      end
   end

   assign status.scan_last = eval_vld_ff && (eval_idx_ff == LAST_IDX);
   assign status.rsp_free  = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_valid) begin
         cap_ff <= csr_wdata;
      end
   end

   // store: one read port (registered), one write port
   always_ff @(posedge clock) begin
      rd_data_ff <= entry_mem[addr_ff];
      if (cmd.commit && wr_en) begin
         entry_mem[wr_idx] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         clock_ff <= '0;
      end else if (cmd.commit && wr_en) begin
         clock_ff <= clock_ff + 1'b1;
         if (insert) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_cmd_ff <= req_tuser[0];
         req_key_ff <= req_tdata[31:0];
         req_val_ff <= req_tdata[63:32];
      end
   end

   // scan issue and evaluate stages
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         addr_done_ff <= 1'b0;
         eval_vld_ff  <= 1'b0;
      end else if (cmd.load_req) begin
         addr_ff      <= '0;
         addr_done_ff <= 1'b0;
         eval_vld_ff  <= 1'b0;
      end else begin
         eval_vld_ff <= cmd.scan_step && !addr_done_ff;
         if (cmd.scan_step && !addr_done_ff) begin
            if (addr_ff == LAST_IDX) begin
               addr_done_ff <= 1'b1;
            end else begin
               addr_ff <= addr_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      eval_idx_ff <= addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_found_ff  <= 1'b0;
         free_found_ff   <= 1'b0;
         victim_found_ff <= 1'b0;
         used_ff         <= '0;
      end else if (cmd.load_req) begin
         match_found_ff  <= 1'b0;
         free_found_ff   <= 1'b0;
         victim_found_ff <= 1'b0;
         used_ff         <= '0;
      end else if (eval_vld_ff) begin
         if (ev_valid) begin
            used_ff <= used_ff + 1'b1;
            if (!match_found_ff && rd_data_ff.key == req_key_ff) begin
               match_found_ff <= 1'b1;
            end
            if (ev_better) begin
               victim_found_ff <= 1'b1;
            end
         end else if (!free_found_ff) begin
            free_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (eval_vld_ff && ev_valid) begin
         if (!match_found_ff && rd_data_ff.key == req_key_ff) begin
            match_idx_ff   <= eval_idx_ff;
            match_data_ff  <= rd_data_ff.data;
            match_count_ff <= rd_data_ff.count;
         end
         if (ev_better) begin
            victim_idx_ff   <= eval_idx_ff;
            victim_count_ff <= rd_data_ff.count;
            victim_stamp_ff <= rd_data_ff.stamp;
         end
      end
      if (eval_vld_ff && !ev_valid && !free_found_ff) begin
         free_idx_ff <= eval_idx_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_hit_ff  <= match_found_ff;
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_hit_ff;
   assign rsp_tdata    = rsp_data_ff;

   a_insert_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && wr_en && insert |=> valid_ff[$past(wr_idx)])
      else $error("inserted entry not marked valid");

   a_clock_step: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && wr_en |=> clock_ff == STAMP_W'($past(clock_ff) + 1'b1))
      else $error("access clock did not advance on touch");

   a_free_seen: assert property (@(posedge clock) disable iff (reset)
      eval_vld_ff && !ev_valid |=> free_found_ff)
      else $error("empty slot missed during scan");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(used_ff) <= CMP_W'(CAPACITY))
      else $error("occupancy count overflow");

endmodule

FILE: tb/sv/lfu_cache_mirror_pkg.sv
`timescale 1ns / 100ps
// Mirror of the LFU cache with LRU tie break: entry store, use counts, access stamps.
// Holds the replies due, in order, and checks each result word against them.
// Depends on lfu_pkg.
package lfu_cache_mirror_pkg;
   import lfu_pkg::*;

   typedef struct {
      logic                     hit;
      logic signed [DATA_W-1:0] read_value;
   } cache_reply_type;

   class cache_mirror_type;
      logic                 entry_valid [CAPACITY_DEF];
      logic [KEY_W-1:0]     entry_key   [CAPACITY_DEF];
      logic [DATA_W-1:0]    entry_data  [CAPACITY_DEF];
      logic [COUNT_W-1:0]   use_count   [CAPACITY_DEF];
      logic [STAMP_W-1:0]   last_stamp  [CAPACITY_DEF];
      logic [STAMP_W-1:0]   access_clock;
      logic [CAP_REG_W-1:0] capacity_reg;
      cache_reply_type      replies_due [$];
      int unsigned          failures;

      function new();
         foreach (entry_valid[i]) entry_valid[i] = 1'b0;
         access_clock = '0;
         capacity_reg = CAP_RESET;
         failures     = 0;
      endfunction

      function void set_capacity(logic [CAP_REG_W-1:0] c);
         capacity_reg = c;
      endfunction

      function int unsigned pending();
         return replies_due.size();
      endfunction

      // one use: saturating count, fresh stamp
      function void touch(int i);
         if (use_count[i] != '1) use_count[i] = use_count[i] + 1'b1;
         last_stamp[i] = access_clock;
         access_clock  = access_clock + 1'b1;
      endfunction

      function void note_request(logic cmd, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
         int              found;
         int              slot;
         int              used;
         int              limit;
         cache_reply_type r;
         found = -1;
         slot  = -1;
         used  = 0;
         limit = (capacity_reg > CAPACITY_DEF) ? CAPACITY_DEF : int'(capacity_reg);
         foreach (entry_valid[i])
            if (found < 0 && entry_valid[i] && entry_key[i] == k) found = i;
         r.hit        = (found >= 0);
         r.read_value = '0;
         if (cmd == CMD_GET) begin
            if (found >= 0) begin
               touch(found);
               r.read_value = entry_data[found];
            end else begin
               r.read_value = MISS_VALUE;
            end
         end else if (limit != 0) begin
            if (found >= 0) begin
               entry_data[found] = v;
               touch(found);
            end else begin
               foreach (entry_valid[i]) if (entry_valid[i]) used++;
               if (used >= limit) begin
                  // lowest count, then oldest stamp, then lowest index
                  foreach (entry_valid[i])
                     if (entry_valid[i] && (slot < 0 || use_count[i] < use_count[slot] ||
                         (use_count[i] == use_count[slot] &&
                          last_stamp[i] < last_stamp[slot])))
                        slot = i;
               end else begin
                  foreach (entry_valid[i])
                     if (slot < 0 && !entry_valid[i]) slot = i;
               end
               if (slot >= 0) begin
                  entry_valid[slot] = 1'b1;
                  entry_key[slot]   = k;
                  entry_data[slot]  = v;
                  use_count[slot]   = 1;
                  last_stamp[slot]  = access_clock;
                  access_clock      = access_clock + 1'b1;
               end
            end
         end
         replies_due.push_back(r);
      endfunction

      function void check_reply(logic hit, logic signed [DATA_W-1:0] rv);
         cache_reply_type want;
         if (replies_due.size() == 0) begin
            $error("result word with no request pending: hit %0d read_value %0d", hit, rv);
            failures++;
            return;
         end
         want = replies_due.pop_front();
         if (hit !== want.hit) begin
            $error("hit mismatch: expected %0d, actual %0d", want.hit, hit);
            failures++;
         end
         if (rv !== want.read_value) begin
            $error("read_value mismatch: expected %0d, actual %0d", want.read_value, rv);
            failures++;
         end
      endfunction
   endclass

endpackage

FILE: tb/sv/lfu_cache_lru_tiebreak_test.sv
`timescale 1ns / 100ps
// Self-checking bench for lfu_cache_lru_tiebreak: directed and random get/put traffic
// under several capacities, checked against the mirror in lfu_cache_mirror_pkg.
// Depends on lfu_pkg, lfu_cache_mirror_pkg and the cache RTL.
module lfu_cache_lru_tiebreak_test;
   import lfu_pkg::*;
   import lfu_cache_mirror_pkg::*;

   localparam int POOL_MAX   = 24;
   localparam int TIMEOUT_NS = 2_000_000;   // well above a slow run
   localparam int HOLD_LEN   = 400;         // long receiver hold-off, in cycles
   localparam int TAIL_WAIT  = 40;          // longer than one request takes to finish

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [0:0]           req_tuser = '0;   // [0] cmd
   logic [63:0]          req_tdata = '0;   // [31:0] key, [63:32] value
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [0:0]           rsp_tuser;        // [0] hit
   logic [31:0]          rsp_tdata;        // [31:0] read_value
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CAP_REG_W-1:0] csr_wdata = '0;

   cache_mirror_type mirror;
   bit               long_hold_req = 1'b0;  // main asks, receiver serves and clears
   logic [KEY_W-1:0] key_pool [POOL_MAX];
   int               pool_size;

   lfu_cache_lru_tiebreak #(.CAPACITY(CAPACITY_DEF)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Hard stop in case the block hangs or drops a result word.
   initial begin
      #(TIMEOUT_NS);
      $display("Test completed with failures");
      $finish;
   end

   // Result monitor: every accepted word is checked against the oldest reply due.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         mirror.check_reply(rsp_tuser[0], rsp_tdata);
   end

   // Receiver: segments of always-ready, mostly-ready, mostly-stalled and a fixed
   // rhythm; on request one long hold-off so the block backs up into req_.
   initial begin
      int mode;
      int seg;
      int tick;
      tick = 0;
      wait (!reset);
      forever begin
         if (long_hold_req) begin
            repeat (HOLD_LEN) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
            end
            long_hold_req = 1'b0;
         end else begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(20, 150);
            repeat (seg) begin
               @(negedge clock);
               tick++;
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= ($urandom_range(0, 3) != 0);
                  2: rsp_tready <= ($urandom_range(0, 3) == 0);
                  default: rsp_tready <= (tick % 5 < 2);
               endcase
            end
         end
      end
   end

   // One request word; valid stays high if the caller sends again straight away.
   task automatic send_request(input logic cmd, input logic [KEY_W-1:0] k,
                               input logic [DATA_W-1:0] v);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {v, k};
      do @(posedge clock); while (!req_tready);
      mirror.note_request(cmd, k, v);
   endtask

   task automatic pause_requests(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic wait_for_replies();
      while (mirror.pending() != 0) @(posedge clock);
   endtask

   // Capacity change only with the cache idle: every reply in means nothing is in flight.
   task automatic write_capacity(input logic [CAP_REG_W-1:0] c);
      pause_requests(1);
      wait_for_replies();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= c;
      do @(posedge clock); while (!csr_ready);
      mirror.set_capacity(c);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random traffic over a small key pool so hits, overwrites and evictions are common;
   // one word in ten takes a fully random key.  hold_at / drain_at < 0 means none.
   task automatic run_phase(input int n_items, input bit no_gaps,
                            input int hold_at, input int drain_at);
      int               burst_left;
      logic [KEY_W-1:0] k;
      pool_size  = $urandom_range(2, POOL_MAX);
      burst_left = 0;
      for (int i = 0; i < POOL_MAX; i++) begin
         case ($urandom_range(0, 15))
            0:       key_pool[i] = 32'h8000_0000;
            1:       key_pool[i] = 32'h7FFF_FFFF;
            2:       key_pool[i] = '1;
            3:       key_pool[i] = '0;
            default: key_pool[i] = $urandom;
         endcase
      end
      for (int n = 0; n < n_items; n++) begin
         if (n == hold_at) long_hold_req = 1'b1;
         if (n == drain_at) begin
            // sender goes quiet until the cache has answered everything
            pause_requests(1);
            wait_for_replies();
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!no_gaps)
               pause_requests(($urandom_range(0, 7) == 0) ? $urandom_range(8, 16)
                                                          : $urandom_range(0, 3));
         end
         burst_left--;
         k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, pool_size - 1)];
         send_request($urandom_range(0, 1) ? CMD_PUT : CMD_GET, k, $urandom);
      end
      pause_requests(1);
   endtask

   initial begin
      int caps [10];
      caps   = '{31, 1, 3, 16, 0, 5, 2, 8, 17, 16};
      mirror = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty miss, key/value extremes, overwrite, hit whose value is all ones
      send_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
      send_request(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
      send_request(CMD_GET, 32'h8000_0000, 32'h0000_0000);
      send_request(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(CMD_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
      send_request(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      send_request(CMD_GET, 32'h5555_5555, 32'hAAAA_AAAA);

      // Capacity zero: puts change nothing but still report presence
      write_capacity(5'd0);
      send_request(CMD_PUT, 32'hAAAA_AAAA, 32'h0000_0001);
      send_request(CMD_PUT, 32'h0000_0000, 32'h0000_0005);
      send_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
      send_request(CMD_GET, 32'hAAAA_AAAA, 32'h0000_0000);

      // Capacity below occupancy: each new key evicts exactly one victim
      write_capacity(5'd2);
      send_request(CMD_PUT, 32'h1111_1111, 32'h0000_0001);
      send_request(CMD_PUT, 32'h2222_2222, 32'h0000_0002);
      send_request(CMD_GET, 32'h1111_1111, 32'h0000_0000);
      send_request(CMD_GET, 32'h2222_2222, 32'h0000_0000);

      // Capacity one: every new key evicts one victim chosen among all live entries
      write_capacity(5'd1);
      send_request(CMD_PUT, 32'h3333_3333, 32'h0000_0003);
      send_request(CMD_GET, 32'h3333_3333, 32'h0000_0000);
      send_request(CMD_GET, 32'h2222_2222, 32'h0000_0000);

      // Random phases across the capacity range, 31 being clamped to the entry count.
      // Phase 3 carries the long receiver hold-off, phase 6 a full drain mid-stream.
      foreach (caps[p]) begin
         write_capacity(CAP_REG_W'(caps[p]));
         run_phase(120, (p % 3 == 2), (p == 3) ? 30 : -1, (p == 6) ? 60 : -1);
      end

      wait_for_replies();
      repeat (TAIL_WAIT) @(posedge clock);
      if (mirror.failures == 0 && mirror.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_ctrl.sv
hw/rtl/lfu_datapath.sv
hw/rtl/lfu_cache_lru_tiebreak.sv
tb/sv/lfu_cache_mirror_pkg.sv
tb/sv/lfu_cache_lru_tiebreak_test.sv
